### hdl/pkrtq_pkg.sv
// ----------------------------------------------------------------------------
// pkrtq_pkg: keypad repeat / touch qualifier package
// Item layouts, register map, button positions and the button remap function.
// ----------------------------------------------------------------------------
package pkrtq_pkg;

  // Number of raw button bits in use (12 to 16); unused upper bits are masked.
  localparam int unsigned KEY_BITS = 16;
  localparam int unsigned KEY_W    = 16;
  localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((33'd1 << KEY_BITS) - 33'd1);

  // Button positions
  localparam int unsigned BTN_A     = 0;
  localparam int unsigned BTN_START = 3;
  localparam int unsigned BTN_R     = 8;
  localparam int unsigned BTN_L     = 9;
  localparam int unsigned BTN_X     = 10;
  localparam int unsigned BTN_Y     = 11;

  // Configuration register map (word index = paddr[3:2])
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;
  localparam logic [1:0] REG_SPEED = 2'd0;
  localparam logic [1:0] REG_WAIT  = 2'd1;
  localparam logic [1:0] REG_REMAP = 2'd2;

  localparam logic [7:0] SPEED_RST = 8'd8;
  localparam logic [7:0] WAIT_RST  = 8'd15;

  typedef enum logic [1:0] {
    REMAP_NONE    = 2'd0,
    REMAP_START_X = 2'd1,
    REMAP_SWAP_XY = 2'd2,
    REMAP_L_A     = 2'd3
  } remap_e;

  // Touch validity codes
  localparam logic [1:0] TV_VALID    = 2'd0;
  localparam logic [1:0] TV_X_BAD    = 2'd1;
  localparam logic [1:0] TV_Y_BAD    = 2'd2;
  localparam logic [1:0] TV_BOTH_BAD = 2'd3;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [3:0]       pad;
    logic [1:0]       touch_validity;
    logic [7:0]       touch_y_in;
    logic [7:0]       touch_x_in;
    logic             touch_down;
    logic [KEY_W-1:0] raw_keys;
    logic             lid_closed;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [5:0]       pad;
    logic             touch_held;
    logic             touch_pressed;
    logic [7:0]       touch_y_out;
    logic [7:0]       touch_x_out;
    logic [KEY_W-1:0] keys_repeat;
    logic [KEY_W-1:0] keys_pressed;
    logic [KEY_W-1:0] keys_held;
  } out_item_t;

  localparam int unsigned IN_W  = $bits(in_item_t);
  localparam int unsigned OUT_W = $bits(out_item_t);

  function automatic logic [KEY_W-1:0] remap_keys(input logic [KEY_W-1:0] k,
                                                  input remap_e mode);
    logic [KEY_W-1:0] r;
    r = k;
    case (mode)
      REMAP_START_X: begin
        if (k[BTN_START]) r[BTN_X] = 1'b1;
      end
      REMAP_SWAP_XY: begin
        r[BTN_X] = k[BTN_Y];
        r[BTN_Y] = k[BTN_X];
      end
      REMAP_L_A: begin
        if (k[BTN_L]) r[BTN_A] = 1'b1;
        r[BTN_L] = 1'b0;
        r[BTN_R] = 1'b0;
      end
      default: r = k;
    endcase
    return r;
  endfunction

endpackage

### hdl/pad_key_repeat_touch_qualifier.sv
// ----------------------------------------------------------------------------
// pad_key_repeat_touch_qualifier: keypad edge detect, auto-repeat and touch
// Derives held / pressed / repeat button masks per frame tick, remaps them and
// qualifies the touch sample against the previous contact state.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake                     | payload
//  ----------+-----------+-------------------------------+-------------------
//  s_axis    | in        | s_axis_tvalid / s_axis_tready | 40-bit tick item
//  m_axis    | out       | m_axis_tvalid / m_axis_tready | 72-bit result item
//  apb       | in        | psel & penable & pwrite       | 3 config registers
//
//  One item per cycle sustained while m_axis_tready stays high. An accepted
//  item is held in the input register, the key/touch logic runs on it in one
//  pass and the result is registered into the output register, which drives
//  m_axis_tvalid and m_axis_tdata.
//  Reset clears the pipeline valids, the key/touch history and the registers
//  to their defaults (speed 8, wait 15, no remap); no clearing pass is needed.
//  An output stall holds the result register; the input register still takes
//  one more item, after which s_axis_tready drops until the result drains.
//
module pad_key_repeat_touch_qualifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tick items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [0] lid_closed, [16:1] raw_keys, [17] touch_down, [25:18] touch_x_in,
  // [33:26] touch_y_in, [35:34] touch_validity, [39:36] zero
  input  logic [pkrtq_pkg::IN_W-1:0]    s_axis_tdata,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [15:0] keys_held, [31:16] keys_pressed, [47:32] keys_repeat,
  // [55:48] touch_x_out, [63:56] touch_y_out, [64] touch_pressed,
  // [65] touch_held, [71:66] zero
  output logic [pkrtq_pkg::OUT_W-1:0]   m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pkrtq_pkg::PADDR_W-1:0] paddr,
  input  logic [pkrtq_pkg::PDATA_W-1:0] pwdata,
  output logic [pkrtq_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import pkrtq_pkg::*;

  // configuration registers
  logic [7:0] speed_q;
  logic [7:0] wait_q;
  remap_e     remap_q;
  logic       cfg_we;
  logic [1:0] reg_idx;

  // pipeline
  logic      in_valid_q;
  in_item_t  in_data_q;
  logic      out_valid_q;
  out_item_t out_data_q;
  logic      advance;
  logic      s_take;

  // tick history
  logic [KEY_W-1:0] prev_keys_q, prev_keys_d;
  logic [7:0]       countdown_q, countdown_d;
  logic [7:0]       touch_x_q, touch_x_d;
  logic [7:0]       touch_y_q, touch_y_d;
  logic             was_held_q, was_held_d;
  out_item_t        result;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // register file: byte address 4*i, lower address bits ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q <= SPEED_RST;
      wait_q  <= WAIT_RST;
      remap_q <= REMAP_NONE;
    end else if (cfg_we) begin
      unique case (reg_idx)
        REG_SPEED: speed_q <= pwdata[7:0];
        REG_WAIT:  wait_q  <= pwdata[7:0];
        REG_REMAP: remap_q <= remap_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SPEED: prdata = {24'd0, speed_q};
      REG_WAIT:  prdata = {24'd0, wait_q};
      REG_REMAP: prdata = {30'd0, remap_q};
      default:   prdata = '0;
    endcase
  end

  // advance the input item into the result register when that slot frees up
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign s_take        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_take) in_data_q <= s_axis_tdata;
    if (advance) out_data_q <= result;
  end

  // one tick of key and touch logic
  always_comb begin
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] pressed;
    logic [KEY_W-1:0] rep;
    logic [7:0]       cd_dec;
    logic             touch;

    keys    = in_data_q.raw_keys & KEY_MASK;
    pressed = keys & ~prev_keys_q;
    rep     = pressed;
    cd_dec  = countdown_q - 8'd1;

    // count down while the word stays unchanged and nonzero, else rearm
    if ((keys != '0) && (keys == prev_keys_q)) begin
      if (cd_dec == 8'd0) begin
        rep         = keys;
        countdown_d = speed_q;
      end else begin
        countdown_d = cd_dec;
      end
    end else begin
      countdown_d = wait_q;
    end
    prev_keys_d = keys;

    // touch: partial coordinate update only while contact is already held
    touch     = in_data_q.touch_down;
    touch_x_d = touch_x_q;
    touch_y_d = touch_y_q;
    if (in_data_q.touch_validity == TV_VALID) begin
      touch_x_d = in_data_q.touch_x_in;
      touch_y_d = in_data_q.touch_y_in;
    end else if (was_held_q) begin
      if (in_data_q.touch_validity == TV_X_BAD) touch_y_d = in_data_q.touch_y_in;
      else if (in_data_q.touch_validity == TV_Y_BAD) touch_x_d = in_data_q.touch_x_in;
    end else begin
      touch = 1'b0;
    end
    was_held_d = touch;

    result               = '0;
    result.keys_held     = remap_keys(keys, remap_q);
    result.keys_pressed  = remap_keys(pressed, remap_q);
    result.keys_repeat   = remap_keys(rep, remap_q);
    result.touch_x_out   = touch_x_d;
    result.touch_y_out   = touch_y_d;
    result.touch_pressed = touch & ~was_held_q;
    result.touch_held    = touch;

    // lid closed: zero the result, drop contact, keep everything else
    if (in_data_q.lid_closed) begin
      result      = '0;
      prev_keys_d = prev_keys_q;
      countdown_d = countdown_q;
      touch_x_d   = touch_x_q;
      touch_y_d   = touch_y_q;
      was_held_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_keys_q <= '0;
      countdown_q <= '0;
      touch_x_q   <= '0;
      touch_y_q   <= '0;
      was_held_q  <= 1'b0;
    end else if (advance) begin
      prev_keys_q <= prev_keys_d;
      countdown_q <= countdown_d;
      touch_x_q   <= touch_x_d;
      touch_y_q   <= touch_y_d;
      was_held_q  <= was_held_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### hdl/pkrtq_checker.sv
// ----------------------------------------------------------------------------
// pkrtq_checker: port-level checks for the keypad repeat / touch qualifier
// Watches the result channel and the relations between its fields.
// ----------------------------------------------------------------------------
module pkrtq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [pkrtq_pkg::OUT_W-1:0] m_axis_tdata
);
  import pkrtq_pkg::*;

  out_item_t res;
  assign res = m_axis_tdata;

  // a stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a newly pressed button is always held
  a_pressed_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.keys_pressed & ~res.keys_held) == '0)
    else $error("pressed button not in held mask");

  // every new press also shows up as a repeat event
  a_pressed_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.keys_pressed & ~res.keys_repeat) == '0)
    else $error("pressed button missing from repeat mask");

  // contact can only begin on a tick where it is held
  a_touch_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.touch_pressed |-> res.touch_held)
    else $error("touch pressed without touch held");

endmodule

bind pad_key_repeat_touch_qualifier pkrtq_checker u_pkrtq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### sim/tb_pad_key_repeat_touch_qualifier.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pad_key_repeat_touch_qualifier: self-checking bench for the keypad block
// Drives frame ticks through the input stream and predicts every result tick
// in the bench. Covers held, pressed and auto-repeat masks in all four remap
// modes, lid suppression and touch qualification. Random stalls and gaps run
// on both streams, and one long output stall backs the block up.
// ----------------------------------------------------------------------------
module tb_pad_key_repeat_touch_qualifier;
  import pkrtq_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 80;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // [0] lid_closed, [16:1] raw_keys, [17] touch_down, [25:18] touch_x_in,
  // [33:26] touch_y_in, [35:34] touch_validity, [39:36] zero
  logic [IN_W-1:0]      s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // [15:0] keys_held, [31:16] keys_pressed, [47:32] keys_repeat,
  // [55:48] touch_x_out, [63:56] touch_y_out, [64] touch_pressed,
  // [65] touch_held, [71:66] zero
  logic [OUT_W-1:0]     m_axis_tdata;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  // Register copy held by the predictor
  logic [7:0]           cfg_speed;
  logic [7:0]           cfg_wait;
  remap_e               cfg_mode;

  // Key and touch history held by the predictor
  logic [KEY_W-1:0]     last_keys;
  logic [7:0]           countdown;
  logic [7:0]           touch_x_kept;
  logic [7:0]           touch_y_kept;
  logic                 contact_held;

  out_item_t            pending_reports[$];
  int                   mismatch_count;
  int                   cycle_count;
  bit                   jitter_on;
  bit                   rx_hold_ask;

  pad_key_repeat_touch_qualifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Abort a hung run; the limit is several times the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_pad_key_repeat_touch_qualifier: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  // Apply the remap mode to one button mask.
  function automatic logic [KEY_W-1:0] remap_mask(input logic [KEY_W-1:0] k);
    logic [KEY_W-1:0] m;
    m = k;
    if (cfg_mode == REMAP_START_X) begin
      if (k[BTN_START]) m[BTN_X] = 1'b1;
    end else if (cfg_mode == REMAP_SWAP_XY) begin
      m[BTN_X] = k[BTN_Y];
      m[BTN_Y] = k[BTN_X];
    end else if (cfg_mode == REMAP_L_A) begin
      if (k[BTN_L]) m[BTN_A] = 1'b1;
      m[BTN_L] = 1'b0;
      m[BTN_R] = 1'b0;
    end
    return m;
  endfunction

  // Advance the key/touch history by one tick and return the report.
  function automatic out_item_t qualify_tick(input in_item_t it);
    out_item_t        r;
    logic [KEY_W-1:0] keys;
    logic [KEY_W-1:0] fresh;
    logic [KEY_W-1:0] rpt;
    logic             touch;
    r = '0;
    // Closed lid: all-zero report, contact dropped, key history kept.
    if (it.lid_closed) begin
      contact_held = 1'b0;
      return r;
    end
    keys  = it.raw_keys & KEY_MASK;
    fresh = keys & ~last_keys;
    rpt   = fresh;
    // Unchanged nonzero word counts down (wrapping at zero), else reload wait.
    if (keys != '0 && keys == last_keys) begin
      countdown = countdown - 8'd1;
      if (countdown == 8'd0) begin
        rpt       = keys;
        countdown = cfg_speed;
      end
    end else begin
      countdown = cfg_wait;
    end
    last_keys = keys;

    touch = it.touch_down;
    if (it.touch_validity == TV_VALID) begin
      touch_x_kept = it.touch_x_in;
      touch_y_kept = it.touch_y_in;
    end else if (contact_held) begin
      // Partial update while contact is held.
      if (it.touch_validity == TV_X_BAD) touch_y_kept = it.touch_y_in;
      else if (it.touch_validity == TV_Y_BAD) touch_x_kept = it.touch_x_in;
    end else begin
      touch = 1'b0;
    end

    r.keys_held     = remap_mask(keys);
    r.keys_pressed  = remap_mask(fresh);
    r.keys_repeat   = remap_mask(rpt);
    r.touch_x_out   = touch_x_kept;
    r.touch_y_out   = touch_y_kept;
    r.touch_pressed = touch & ~contact_held;
    r.touch_held    = touch;
    contact_held    = touch;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stream drivers and result checker
  // --------------------------------------------------------------------------

  // Pick an idle stretch: mostly none, some short, a few long.
  function automatic int idle_gap();
    int roll;
    if (!jitter_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one tick, wait for acceptance, then predict its report.
  task automatic send_tick(input in_item_t it);
    int gap;
    gap = idle_gap();
    it.pad = '0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_reports.push_back(qualify_tick(it));
  endtask

  // Drop the input stream and wait until every report has come back.
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Output ready: random stalls, plus one long hold-off on request.
  initial begin : rx_drive
    int stall;
    int held;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_ask) begin
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HOLD_CYCLES) begin
          @(negedge clk_i);
          held++;
        end
        rx_hold_ask = 1'b0;
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        stall = idle_gap();
        m_axis_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare each accepted report with the oldest prediction.
  initial begin : report_check
    out_item_t got;
    out_item_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (pending_reports.size() == 0) begin
          $error("report %0h arrived with no tick outstanding", got);
          mismatch_count++;
        end else begin
          want = pending_reports.pop_front();
          check_field("keys_held", want.keys_held, got.keys_held);
          check_field("keys_pressed", want.keys_pressed, got.keys_pressed);
          check_field("keys_repeat", want.keys_repeat, got.keys_repeat);
          check_field("touch_x_out", 16'(want.touch_x_out), 16'(got.touch_x_out));
          check_field("touch_y_out", 16'(want.touch_y_out), 16'(got.touch_y_out));
          check_field("touch_pressed", 16'(want.touch_pressed), 16'(got.touch_pressed));
          check_field("touch_held", 16'(want.touch_held), 16'(got.touch_held));
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Register access
  // --------------------------------------------------------------------------

  task automatic apb_cycle(input logic write_en, input logic [1:0] idx,
                           input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write_en;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic [1:0] idx, input logic [7:0] want);
    logic [31:0] rd;
    logic [31:0] mask;
    mask = (idx == REG_REMAP) ? 32'h3 : 32'hff;
    apb_cycle(1'b0, idx, 32'h0, rd);
    if ((rd & mask) !== ({24'h0, want} & mask)) begin
      $error("register %0d: expected %0h, actual %0h", idx, want, rd & mask);
      mismatch_count++;
    end
  endtask

  // Write a register while idle, mirror it in the predictor, read it back.
  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] rd;
    quiesce();
    apb_cycle(1'b1, idx, {24'h0, val}, rd);
    if (idx == REG_SPEED) cfg_speed = val;
    else if (idx == REG_WAIT) cfg_wait = val;
    else if (idx == REG_REMAP) cfg_mode = remap_e'(val[1:0]);
    check_register(idx, val);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic in_item_t make_tick(input logic lid, input logic [15:0] keys,
                                         input logic tdown, input logic [7:0] tx,
                                         input logic [7:0] ty, input logic [1:0] tv);
    in_item_t it;
    it                = '0;
    it.lid_closed     = lid;
    it.raw_keys       = keys;
    it.touch_down     = tdown;
    it.touch_x_in     = tx;
    it.touch_y_in     = ty;
    it.touch_validity = tv;
    return it;
  endfunction

  // Given keys, fill the touch fields at random; contact mostly present.
  function automatic in_item_t random_tick(input logic [15:0] keys);
    logic [1:0] tv;
    tv = ($urandom_range(0, 1) == 0) ? TV_VALID : 2'($urandom_range(1, 3));
    return make_tick(1'b0, keys, ($urandom_range(0, 3) != 0), 8'($urandom),
                     8'($urandom), tv);
  endfunction

  // Favor the remapped buttons and the all-zero / all-one words.
  function automatic logic [15:0] random_keys();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'h1 << $urandom_range(0, 15);
      3: return (16'h1 << BTN_START) | (16'h1 << BTN_L) | (16'($urandom) & 16'h0c00);
      4: return (16'h1 << BTN_X) | (16'h1 << BTN_Y) | (16'($urandom) & 16'h0301);
      default: return 16'($urandom);
    endcase
  endfunction

  // Pick a repeat period: mostly short so repeats fire, sometimes extreme.
  function automatic logic [7:0] random_period();
    case ($urandom_range(0, 9))
      0: return 8'd1;
      1: return 8'd255;
      2: return 8'd0;
      default: return 8'($urandom_range(1, 8));
    endcase
  endfunction

  task automatic hold_keys(input logic [15:0] keys, input int ticks);
    repeat (ticks) send_tick(random_tick(keys));
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  task automatic test_reset_values();
    check_register(REG_SPEED, SPEED_RST);
    check_register(REG_WAIT, WAIT_RST);
    check_register(REG_REMAP, 8'(REMAP_NONE));
  endtask

  // Rising and falling edges of the all-zero and all-one words.
  task automatic test_key_edges();
    send_tick(make_tick(1'b0, 16'h0000, 1'b0, 8'h00, 8'h00, TV_VALID));
    send_tick(make_tick(1'b0, 16'hffff, 1'b0, 8'h00, 8'h00, TV_VALID));
    send_tick(make_tick(1'b0, 16'hffff, 1'b0, 8'hff, 8'hff, TV_VALID));
    send_tick(make_tick(1'b0, 16'h0000, 1'b0, 8'hff, 8'hff, TV_VALID));
  endtask

  // Walk every remap mode over START, X, Y with L, and R alone.
  task automatic test_remap_modes();
    remap_e mode;
    mode = mode.first();
    do begin
      write_register(REG_REMAP, 8'(mode));
      send_tick(make_tick(1'b0, 16'h1 << BTN_START, 1'b0, 8'h00, 8'h00, TV_VALID));
      send_tick(make_tick(1'b0, 16'h1 << BTN_X, 1'b0, 8'h00, 8'h00, TV_VALID));
      send_tick(make_tick(1'b0, (16'h1 << BTN_Y) | (16'h1 << BTN_L), 1'b0, 8'h00,
                          8'h00, TV_VALID));
      send_tick(make_tick(1'b0, 16'h1 << BTN_R, 1'b0, 8'h00, 8'h00, TV_VALID));
      mode = mode.next();
    end while (mode != mode.first());
    write_register(REG_REMAP, 8'(REMAP_NONE));
  endtask

  // Closed lid zeroes everything and drops contact; keys survive it.
  task automatic test_lid_closed();
    send_tick(make_tick(1'b0, 16'h0001, 1'b1, 8'h12, 8'h34, TV_VALID));
    send_tick(make_tick(1'b1, 16'hffff, 1'b1, 8'hff, 8'hff, TV_VALID));
    // contact was dropped by the lid, so an invalid sample is absent
    send_tick(make_tick(1'b0, 16'h0001, 1'b1, 8'h56, 8'h78, TV_X_BAD));
  endtask

  // Invalid samples with and without a held contact, every validity code.
  task automatic test_touch_qualify();
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'h00, 8'h00, TV_VALID));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'hff, 8'hff, TV_X_BAD));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'haa, 8'h55, TV_Y_BAD));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'h11, 8'h22, TV_BOTH_BAD));
    send_tick(make_tick(1'b0, 16'h0000, 1'b0, 8'h80, 8'h01, TV_VALID));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'h33, 8'h44, TV_BOTH_BAD));
    send_tick(make_tick(1'b0, 16'h0000, 1'b1, 8'hff, 8'hff, TV_VALID));
  endtask

  // Short and maximum wait/speed, with a steady word held past them.
  task automatic test_repeat_timing();
    write_register(REG_SPEED, 8'd1);
    write_register(REG_WAIT, 8'd1);
    hold_keys(16'h0001, 6);
    write_register(REG_SPEED, 8'd3);
    write_register(REG_WAIT, 8'd2);
    hold_keys(16'h8008, 12);
    write_register(REG_SPEED, 8'd255);
    write_register(REG_WAIT, 8'd255);
    hold_keys(16'h0c00, 260);
  endtask

  // Zero in a repeat register behaves as a 256-tick period.
  task automatic test_zero_period();
    write_register(REG_SPEED, 8'd0);
    write_register(REG_WAIT, 8'd0);
    hold_keys(16'h0200, 262);
  endtask

  // Phases of random settings; runs of one word so repeats get to fire,
  // with single-tick runs, lid blips and invalid touches as noise.
  task automatic test_random_play();
    in_item_t    it;
    logic [15:0] word;
    int          run;
    int          sent;
    for (int phase = 0; phase < 8; phase++) begin
      jitter_on = (phase % 3 != 2);
      write_register(REG_SPEED, random_period());
      write_register(REG_WAIT, random_period());
      write_register(REG_REMAP, 8'($urandom_range(0, 3)));
      sent = 0;
      while (sent < 125) begin
        word = random_keys();
        run  = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 24);
        for (int k = 0; k < run && sent < 125; k++) begin
          it            = random_tick(word);
          it.lid_closed = ($urandom_range(0, 39) == 0);
          send_tick(it);
          sent++;
        end
      end
    end
    jitter_on = 1'b1;
  endtask

  // Hold the output off long enough that the block backs up its input.
  task automatic test_output_stall();
    quiesce();
    jitter_on   = 1'b0;
    rx_hold_ask = 1'b1;
    repeat (40) send_tick(random_tick(random_keys()));
    jitter_on   = 1'b1;
    quiesce();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : run_tests
    // Drive every input to a known value from time zero.
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    jitter_on      = 1'b1;
    rx_hold_ask    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    // Predictor starts from the block's reset state.
    cfg_speed      = SPEED_RST;
    cfg_wait       = WAIT_RST;
    cfg_mode       = REMAP_NONE;
    last_keys      = '0;
    countdown      = '0;
    touch_x_kept   = '0;
    touch_y_kept   = '0;
    contact_held   = 1'b0;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_values();
    test_key_edges();
    test_remap_modes();
    test_lid_closed();
    test_touch_qualify();
    test_repeat_timing();
    test_zero_period();
    test_random_play();
    test_output_stall();

    // Let any stray report show up before the verdict.
    quiesce();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_pad_key_repeat_touch_qualifier: done, clean");
    end else begin
      $display("tb_pad_key_repeat_touch_qualifier: done, errors");
    end
    $finish;
  end

endmodule

### sim.f
hdl/pkrtq_pkg.sv
hdl/pad_key_repeat_touch_qualifier.sv
hdl/pkrtq_checker.sv
sim/tb_pad_key_repeat_touch_qualifier.sv
